### design/pmt_pkg.sv
// Shared constants and codes for the prescaled match timer.
package pmt_pkg;

    // Default counter width
    localparam int COUNTER_WIDTH_DEF = 32;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int MASK_W   = 2;
    localparam int INDEX_W  = 3;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [INDEX_W-1:0]  reg_index_t;

    // Item actions
    localparam action_t ACT_TICK  = 3'd0;
    localparam action_t ACT_START = 3'd1;
    localparam action_t ACT_HOLD  = 3'd2;
    localparam action_t ACT_STOP  = 3'd3;
    localparam action_t ACT_CLEAR = 3'd4;

    // Configuration register indexes
    localparam reg_index_t REG_PRESCALE       = 3'd0;
    localparam reg_index_t REG_PERIOD_MATCH   = 3'd1;
    localparam reg_index_t REG_DUTY_MATCH     = 3'd2;
    localparam reg_index_t REG_PWM_MODE       = 3'd3;
    localparam reg_index_t REG_RESET_ON_MATCH = 3'd4;
    localparam reg_index_t REG_STOP_ON_MATCH  = 3'd5;
    localparam reg_index_t REG_IRQ_ENABLE     = 3'd6;
    localparam reg_index_t REG_PERIOD_LIMIT   = 3'd7;

endpackage

### design/prescaled_match_timer.sv
// Top level of the prescaled match timer channel.
//
// Usage:
//   Items (action, clear_mask) arrive on a valid/ready channel: tick, start,
//   hold reset, stop and clear flags. Every accepted item yields exactly one
//   result transfer with the counter value, run state, match flags, irq level
//   and an auto-stop marker for that item.
//   Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data),
//   written by the user only while the channel is idle (not enforced here);
//   writing period_limit also clears the period count unless an item transfers.
//   Latency: the result is presented the cycle after the item transfer.
//   Throughput: one item per cycle unless stalled; state updates in a single
//   pass at the transfer edge and the result sits in an output register.
//   Stall: while result_ready is low a held result blocks further items;
//   item_ready rises again in the cycle the result is taken.
//   Reset: counter, prescaler, flags and period count clear, the timer is
//   stopped, and the registers take their reset values (reset and stop on
//   match set, all else zero).
module prescaled_match_timer #(
    parameter int COUNTER_WIDTH = pmt_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write_en,
    input  logic [pmt_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [pmt_pkg::DATA_W-1:0]    cfg_data,
    // items
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [pmt_pkg::ACTION_W-1:0]  action,
    input  logic [pmt_pkg::MASK_W-1:0]    clear_mask,
    // results
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [pmt_pkg::DATA_W-1:0]    count_value,
    output logic                          running,
    output logic                          first_match_flag,
    output logic                          second_match_flag,
    output logic                          irq,
    output logic                          auto_stopped
);

    // compare width: wide enough for the counter and the 32-bit match values
    localparam int CMP_W = (COUNTER_WIDTH > pmt_pkg::DATA_W) ? COUNTER_WIDTH
                                                             : pmt_pkg::DATA_W;
    localparam int DW    = pmt_pkg::DATA_W;

    // configuration registers
    logic [DW-1:0] prescale_reg;
    logic [DW-1:0] period_match_reg;
    logic [DW-1:0] duty_match_reg;
    logic          pwm_mode_reg;
    logic          reset_on_match_reg;
    logic          stop_on_match_reg;
    logic          irq_enable_reg;
    logic [DW-1:0] period_limit_reg;

    // timer state
    logic [DW-1:0]            prescale_count_reg, prescale_count_next;
    logic [COUNTER_WIDTH-1:0] counter_reg, counter_next;
    logic                     enabled_reg, enabled_next;
    logic [1:0]               match_flags_reg, match_flags_next;
    logic [DW-1:0]            periods_done_reg, periods_done_next;

    // output stage
    logic          result_valid_reg;
    logic [DW-1:0] count_value_reg;
    logic          running_reg;
    logic [1:0]    flags_out_reg;
    logic          auto_stopped_reg, auto_stopped_next;

    logic item_xfer;

    // counter step terms
    logic [COUNTER_WIDTH-1:0] cand;
    logic [CMP_W-1:0]         cand_ext;
    logic [CMP_W-1:0]         counter_ext;
    logic                     period_hit;
    logic                     duty_hit;
    logic                     first_hit;
    logic                     limit_on;
    logic [DW-1:0]            periods_inc;

    assign item_ready = !result_valid_reg || result_ready;
    assign item_xfer  = item_valid && item_ready;

    assign cand        = counter_reg + COUNTER_WIDTH'(1);
    assign cand_ext    = CMP_W'(cand);
    assign period_hit  = (cand_ext == CMP_W'(period_match_reg));
    assign duty_hit    = (cand_ext == CMP_W'(duty_match_reg));
    // first match register: duty in PWM mode, period otherwise
    assign first_hit   = pwm_mode_reg ? duty_hit : period_hit;
    assign limit_on    = (period_limit_reg != '0);
    assign periods_inc = (periods_done_reg != '1) ? periods_done_reg + DW'(1)
                                                  : periods_done_reg;

    // next state for one item
    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        counter_next        = counter_reg;
        enabled_next        = enabled_reg;
        match_flags_next    = match_flags_reg;
        periods_done_next   = periods_done_reg;
        auto_stopped_next   = 1'b0;

        unique case (action)
            pmt_pkg::ACT_TICK:
            begin
                if (enabled_reg)
                begin
                    if (prescale_count_reg == prescale_reg)
                    begin
                        prescale_count_next = '0;
                        counter_next        = cand;
                        if (first_hit)
                        begin
                            if (irq_enable_reg || limit_on)
                                match_flags_next[0] = 1'b1;
                            if (limit_on)
                            begin
                                periods_done_next = periods_inc;
                                if (periods_inc >= period_limit_reg)
                                begin
                                    enabled_next      = 1'b0;
                                    auto_stopped_next = 1'b1;
                                end
                            end
                        end
                        if (pwm_mode_reg)
                        begin
                            if (period_hit)
                            begin
                                if (irq_enable_reg)
                                    match_flags_next[1] = 1'b1;
                                counter_next = '0;
                            end
                        end
                        else if (period_hit)
                        begin
                            if (reset_on_match_reg)
                                counter_next = '0;
                            if (stop_on_match_reg)
                                enabled_next = 1'b0;
                        end
                    end
                    else
                    begin
                        prescale_count_next = prescale_count_reg + DW'(1);
                    end
                end
            end
            pmt_pkg::ACT_START:
                enabled_next = 1'b1;
            pmt_pkg::ACT_HOLD:
            begin
                prescale_count_next = '0;
                counter_next        = '0;
                enabled_next        = 1'b0;
            end
            pmt_pkg::ACT_STOP:
                enabled_next = 1'b0;
            pmt_pkg::ACT_CLEAR:
                match_flags_next = match_flags_reg & ~clear_mask;
            default:
                ; // spare codes leave the state alone
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg       <= '0;
            period_match_reg   <= '0;
            duty_match_reg     <= '0;
            pwm_mode_reg       <= 1'b0;
            reset_on_match_reg <= 1'b1;
            stop_on_match_reg  <= 1'b1;
            irq_enable_reg     <= 1'b0;
            period_limit_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                pmt_pkg::REG_PRESCALE:       prescale_reg       <= cfg_data;
                pmt_pkg::REG_PERIOD_MATCH:   period_match_reg   <= cfg_data;
                pmt_pkg::REG_DUTY_MATCH:     duty_match_reg     <= cfg_data;
                pmt_pkg::REG_PWM_MODE:       pwm_mode_reg       <= cfg_data[0];
                pmt_pkg::REG_RESET_ON_MATCH: reset_on_match_reg <= cfg_data[0];
                pmt_pkg::REG_STOP_ON_MATCH:  stop_on_match_reg  <= cfg_data[0];
                pmt_pkg::REG_IRQ_ENABLE:     irq_enable_reg     <= cfg_data[0];
                pmt_pkg::REG_PERIOD_LIMIT:   period_limit_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // timer state; a period_limit write restarts the period count unless an item transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            counter_reg        <= '0;
            enabled_reg        <= 1'b0;
            match_flags_reg    <= '0;
            periods_done_reg   <= '0;
        end
        else if (item_xfer)
        begin
            prescale_count_reg <= prescale_count_next;
            counter_reg        <= counter_next;
            enabled_reg        <= enabled_next;
            match_flags_reg    <= match_flags_next;
            periods_done_reg   <= periods_done_next;
        end
        else if (cfg_write_en && (cfg_index == pmt_pkg::REG_PERIOD_LIMIT))
        begin
            periods_done_reg <= '0;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (item_xfer)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // result payload
    assign counter_ext = CMP_W'(counter_next);

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            count_value_reg  <= counter_ext[DW-1:0];
            running_reg      <= enabled_next;
            flags_out_reg    <= match_flags_next;
            auto_stopped_reg <= auto_stopped_next;
        end
    end

    assign result_valid      = result_valid_reg;
    assign count_value       = count_value_reg;
    assign running           = running_reg;
    assign first_match_flag  = flags_out_reg[0];
    assign second_match_flag = flags_out_reg[1];
    assign irq               = |flags_out_reg;
    assign auto_stopped      = auto_stopped_reg;

endmodule
